// File: rtl/prime_factorizer_assert.svh
// Assertion macros for the prime factorizer; the including module supplies clk and rst.
`ifndef PRIME_FACTORIZER_ASSERT_SVH
`define PRIME_FACTORIZER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define PF_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that holds in the same cycle as its trigger.
`define PF_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that holds in the cycle after its trigger.
`define PF_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pf_pkg.sv
// Shared constants, types and state encoding of the prime factorizer.
`timescale 1ns / 1ps
`default_nettype none

package pf_pkg;

  localparam int unsigned PRIME_LIMIT_DEF = 65536;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned IN_W        = 32;
  localparam int unsigned PRIME_W     = 32;
  localparam int unsigned EXP_W       = 6;
  localparam int unsigned MAX_RESULTS = 9;
  localparam int unsigned CNT_W       = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RESULTS);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_SIEVE_RD,
    S_SIEVE_WAIT,
    S_MARK,
    S_IDLE,
    S_TEST,
    S_LOOK,
    S_DIV,
    S_CHECK,
    S_PUSH,
    S_TAIL,
    S_PUSH_TAIL,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic [PRIME_W-1:0] prime_factor;
    logic [EXP_W-1:0]   exponent;
    logic               no_factor;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/pf_channel_if.sv
// Valid/ready channel interfaces for the input and result words of the prime factorizer.
`timescale 1ns / 1ps
`default_nettype none

interface pf_in_if;
  logic                      valid;
  logic                      ready;
  logic [pf_pkg::IN_W-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface pf_out_if;
  logic                       valid;
  logic                       ready;
  logic [pf_pkg::PRIME_W-1:0] prime_factor;
  logic [pf_pkg::EXP_W-1:0]   exponent;
  logic                       no_factor;
  logic                       last;

  modport source (output valid, output prime_factor, output exponent, output no_factor,
                  output last, input ready);
  modport sink (input valid, input prime_factor, input exponent, input no_factor,
                input last, output ready);
endinterface

`default_nettype wire

// File: rtl/prime_factorizer.sv
// Prime factorizer: sieved prime table in a memory and trial division by a serial divider.
//
// The block takes one unsigned word per item on din and returns, on dout, one word per
// distinct prime factor in ascending order with its exponent; last marks the final word.
// Values 0 and 1 give a single word with no_factor set. A residue that is left when the
// prime table runs out is returned with exponent 1. At most nine words come per item.
// After reset the block clears its composite map and then sieves it; din.ready stays low
// until it is done. An item is taken only while no other item is in progress. Each prime
// candidate whose square does not exceed the residue is tried by the one bit per cycle
// divider, which repeats the division while it leaves no remainder; a composite candidate
// is skipped once the memory read marks it, and a value of 0 or 1 goes straight to its
// final word.
// Results leave through an output register, and one word is held back until it is known
// whether another follows. When dout stalls, the block waits with its next word and the
// division work stops; the final word of an item may wait in the output register while
// the next item is already being taken.
`timescale 1ns / 1ps
`default_nettype none

module prime_factorizer #(
  parameter int unsigned PRIME_LIMIT = pf_pkg::PRIME_LIMIT_DEF,
  parameter int unsigned VALUE_WIDTH = pf_pkg::VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pf_in_if.sink     din,
  pf_out_if.source  dout
);

  `include "prime_factorizer_assert.svh"

  localparam int unsigned PW  = $clog2(PRIME_LIMIT);
  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned SW  = 2 * PW + 2;
  localparam int unsigned CW  = (SW > VW) ? SW : VW;
  localparam int unsigned DCW = $clog2(VW);

  localparam logic [PW:0]    LIMIT_P  = (PW + 1)'(PRIME_LIMIT);
  localparam logic [PW-1:0]  CLR_LAST = PW'(PRIME_LIMIT - 1);
  localparam logic [SW-1:0]  LIMIT_S  = SW'(PRIME_LIMIT);
  localparam logic [PW:0]    TWO_P    = (PW + 1)'(2);
  localparam logic [SW-1:0]  FOUR_S   = SW'(4);
  localparam logic [DCW-1:0] DCNT_TOP = DCW'(VW - 1);

  pf_pkg::state_t state, state_next;

  logic                     map_mem [PRIME_LIMIT];
  logic                     mem_rdata;
  logic                     mem_we, mem_re, mem_wdata;
  logic [PW-1:0]            mem_addr;

  logic [PW-1:0]            clr;
  logic [PW:0]              p;
  logic [SW-1:0]            sq;
  logic [PW:0]              j;
  logic [VW-1:0]            n;
  logic [VW-1:0]            dvd;
  logic [PW:0]              rem;
  logic [DCW-1:0]           dcnt;
  logic [pf_pkg::EXP_W-1:0] e;
  logic [pf_pkg::CNT_W-1:0] cnt;
  pf_pkg::result_t          pend;
  logic                     pend_valid;
  pf_pkg::result_t          out_res;
  logic                     out_last;
  logic                     out_valid;

  logic [SW-1:0]            sq_inc;
  logic                     sq_ge_limit, p_end, sq_gt_n, j_end;
  logic [PW:0]              rem_sh;
  logic                     sub_ok;
  logic                     out_free;
  logic                     out_load;
  logic [VW-1:0]            in_n;
  logic                     in_small;
  logic                     cnt_full;
  logic                     push_ok;
  pf_pkg::result_t          new_res;

  assign sq_inc      = sq + SW'({p, 1'b1});
  assign sq_ge_limit = sq >= LIMIT_S;
  assign p_end       = p >= LIMIT_P;
  assign sq_gt_n     = CW'(sq) > CW'(n);
  assign j_end       = j >= LIMIT_P;
  assign rem_sh      = {rem[PW-1:0], dvd[VW-1]};
  assign sub_ok      = rem_sh >= p;
  assign out_free    = !out_valid || dout.ready;
  assign in_n        = VW'(din.value);
  assign in_small    = in_n[VW-1:1] == '0;
  assign cnt_full    = cnt >= pf_pkg::CNT_MAX;
  assign push_ok     = !pend_valid || out_free;
  assign out_load    = ((state inside {pf_pkg::S_PUSH, pf_pkg::S_PUSH_TAIL}) && push_ok
                        && pend_valid) || (state == pf_pkg::S_FINAL && out_free);

  always_comb begin
    if (state == pf_pkg::S_PUSH_TAIL) begin
      new_res.prime_factor = pf_pkg::PRIME_W'(n);
      new_res.exponent     = pf_pkg::EXP_W'(1);
    end else begin
      new_res.prime_factor = pf_pkg::PRIME_W'(p);
      new_res.exponent     = e;
    end
    new_res.no_factor = 1'b0;
  end

  always_comb begin
    state_next = state;
    case (state)
      pf_pkg::S_CLEAR: begin
        if (clr == CLR_LAST) state_next = pf_pkg::S_SIEVE_RD;
      end
      pf_pkg::S_SIEVE_RD: begin
        state_next = sq_ge_limit ? pf_pkg::S_IDLE : pf_pkg::S_SIEVE_WAIT;
      end
      pf_pkg::S_SIEVE_WAIT: begin
        state_next = mem_rdata ? pf_pkg::S_SIEVE_RD : pf_pkg::S_MARK;
      end
      pf_pkg::S_MARK: begin
        if (j_end) state_next = pf_pkg::S_SIEVE_RD;
      end
      pf_pkg::S_IDLE: begin
        if (din.valid) state_next = in_small ? pf_pkg::S_FINAL : pf_pkg::S_TEST;
      end
      pf_pkg::S_TEST: begin
        state_next = (p_end || sq_gt_n) ? pf_pkg::S_TAIL : pf_pkg::S_LOOK;
      end
      pf_pkg::S_LOOK: begin
        state_next = mem_rdata ? pf_pkg::S_TEST : pf_pkg::S_DIV;
      end
      pf_pkg::S_DIV: begin
        if (dcnt == '0) state_next = pf_pkg::S_CHECK;
      end
      pf_pkg::S_CHECK: begin
        if (rem == '0) state_next = pf_pkg::S_DIV;
        else if (e != '0 && !cnt_full) state_next = pf_pkg::S_PUSH;
        else state_next = pf_pkg::S_TEST;
      end
      pf_pkg::S_PUSH: begin
        if (push_ok) state_next = pf_pkg::S_TEST;
      end
      pf_pkg::S_TAIL: begin
        state_next = (n[VW-1:1] != '0 && !cnt_full) ? pf_pkg::S_PUSH_TAIL : pf_pkg::S_FINAL;
      end
      pf_pkg::S_PUSH_TAIL: begin
        if (push_ok) state_next = pf_pkg::S_FINAL;
      end
      pf_pkg::S_FINAL: begin
        if (out_free) state_next = pf_pkg::S_IDLE;
      end
      default: state_next = pf_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = 1'b1;
    mem_addr  = p[PW-1:0];
    case (state)
      pf_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr;
        mem_wdata = clr[PW-1:1] == '0;
      end
      pf_pkg::S_SIEVE_RD: begin
        mem_re = !sq_ge_limit;
      end
      pf_pkg::S_MARK: begin
        mem_we   = !j_end;
        mem_addr = j[PW-1:0];
      end
      pf_pkg::S_TEST: begin
        mem_re = !(p_end || sq_gt_n);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  assign din.ready         = state == pf_pkg::S_IDLE;
  assign dout.valid        = out_valid;
  assign dout.prime_factor = out_res.prime_factor;
  assign dout.exponent     = out_res.exponent;
  assign dout.no_factor    = out_res.no_factor;
  assign dout.last         = out_last;

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_addr] <= mem_wdata;
    if (mem_re) mem_rdata <= map_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pf_pkg::S_CLEAR;
      clr        <= '0;
      p          <= TWO_P;
      sq         <= FOUR_S;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        pf_pkg::S_CLEAR: begin
          clr <= clr + 1'b1;
        end
        pf_pkg::S_SIEVE_WAIT: begin
          if (mem_rdata) begin
            p  <= p + 1'b1;
            sq <= sq_inc;
          end else begin
            j <= (PW + 1)'(sq);
          end
        end
        pf_pkg::S_MARK: begin
          if (j_end) begin
            p  <= p + 1'b1;
            sq <= sq_inc;
          end else begin
            j <= j + p;
          end
        end
        pf_pkg::S_IDLE: begin
          if (din.valid) begin
            n          <= in_n;
            p          <= TWO_P;
            sq         <= FOUR_S;
            cnt        <= '0;
            pend_valid <= in_small;
            pend       <= '{prime_factor: '0, exponent: '0, no_factor: 1'b1};
          end
        end
        pf_pkg::S_LOOK: begin
          if (mem_rdata) begin
            p  <= p + 1'b1;
            sq <= sq_inc;
          end else begin
            dvd  <= n;
            rem  <= '0;
            dcnt <= DCNT_TOP;
            e    <= '0;
          end
        end
        pf_pkg::S_DIV: begin
          dvd  <= {dvd[VW-2:0], sub_ok};
          rem  <= sub_ok ? rem_sh - p : rem_sh;
          dcnt <= dcnt - 1'b1;
        end
        pf_pkg::S_CHECK: begin
          if (rem == '0) begin
            n    <= dvd;
            e    <= e + 1'b1;
            dcnt <= DCNT_TOP;
          end else if (!(e != '0 && !cnt_full)) begin
            p  <= p + 1'b1;
            sq <= sq_inc;
          end
        end
        pf_pkg::S_PUSH, pf_pkg::S_PUSH_TAIL: begin
          if (push_ok) begin
            if (pend_valid) begin
              out_res  <= pend;
              out_last <= 1'b0;
            end
            pend       <= new_res;
            pend_valid <= 1'b1;
            cnt        <= cnt + 1'b1;
            if (state == pf_pkg::S_PUSH) begin
              p  <= p + 1'b1;
              sq <= sq_inc;
            end
          end
        end
        pf_pkg::S_FINAL: begin
          if (out_free) begin
            out_res    <= pend_valid ? pend : '0;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  `PF_CHECK(a_cnt_bound, cnt <= pf_pkg::CNT_MAX, "result count beyond its bound")
  `PF_IMPLIES(a_div_divisor, state == pf_pkg::S_DIV, p >= TWO_P, "division by a divisor below two")
  `PF_NEXT(a_small_value, din.valid && din.ready && in_small, state == pf_pkg::S_FINAL && pend_valid && pend.no_factor, "small value did not give a no-factor word")
  `PF_NEXT(a_final_last, state == pf_pkg::S_FINAL && out_free, dout.valid && dout.last, "final word not flagged as last")

endmodule

`default_nettype wire

// File: sim/prime_factorizer_tb.sv
// Self-checking testbench for prime_factorizer: directed and random values, idling and stalls.
`timescale 1ns / 1ps

module prime_factorizer_tb;

  localparam int unsigned PRIME_LIMIT = pf_pkg::PRIME_LIMIT_DEF;
  localparam int unsigned VALUE_WIDTH = pf_pkg::VALUE_WIDTH_DEF;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [pf_pkg::PRIME_W-1:0] prime_factor;
    logic [pf_pkg::EXP_W-1:0]   exponent;
    logic                       no_factor;
    logic                       last;
  } factor_word_t;

  logic clk = 1'b0;
  logic rst;

  pf_in_if  din_if ();
  pf_out_if dout_if ();

  prime_factorizer #(
    .PRIME_LIMIT(PRIME_LIMIT),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .din(din_if),
    .dout(dout_if)
  );

  bit           not_prime [PRIME_LIMIT];
  factor_word_t pending_factors [$];
  int unsigned  src_idle_pct = 0;
  int unsigned  snk_stall_pct = 0;
  int unsigned  values_sent = 0;
  int unsigned  words_checked = 0;
  int unsigned  failures = 0;

  always #2 clk = ~clk;

  function automatic void report_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void add_expected(input factor_word_t w);
    pending_factors = {pending_factors, w};
  endfunction

  function automatic void build_prime_table();
    longint unsigned i;
    longint unsigned j;
    foreach (not_prime[k]) not_prime[k] = 1'b0;
    not_prime[0] = 1'b1;
    not_prime[1] = 1'b1;
    for (i = 2; i * i < PRIME_LIMIT; i++) begin
      if (!not_prime[i]) begin
        for (j = i * i; j < PRIME_LIMIT; j += i) not_prime[j] = 1'b1;
      end
    end
  endfunction

  function automatic void predict_factors(input logic [pf_pkg::IN_W-1:0] value);
    longint unsigned n;
    longint unsigned p;
    int unsigned     e;
    int unsigned     count;
    factor_word_t    w;
    n = longint'(value) & ((64'd1 << VALUE_WIDTH) - 64'd1);
    if (n <= 1) begin
      w = '{prime_factor: '0, exponent: '0, no_factor: 1'b1, last: 1'b1};
      add_expected(w);
      return;
    end
    count = 0;
    for (p = 2; p < PRIME_LIMIT; p++) begin
      if (p * p > n) break;
      if (!not_prime[p]) begin
        e = 0;
        while (n % p == 0) begin
          n = n / p;
          e++;
        end
        if (e > 0 && count < pf_pkg::MAX_RESULTS) begin
          w = '{prime_factor: pf_pkg::PRIME_W'(p), exponent: pf_pkg::EXP_W'(e),
                no_factor: 1'b0, last: 1'b0};
          add_expected(w);
          count++;
        end
      end
    end
    if (n >= 2 && count < pf_pkg::MAX_RESULTS) begin
      w = '{prime_factor: pf_pkg::PRIME_W'(n), exponent: pf_pkg::EXP_W'(1),
            no_factor: 1'b0, last: 1'b0};
      add_expected(w);
      count++;
    end
    if (count == 0) begin
      w = '{prime_factor: '0, exponent: '0, no_factor: 1'b0, last: 1'b0};
      add_expected(w);
    end
    pending_factors[$].last = 1'b1;
  endfunction

  function automatic int unsigned random_prime(input int unsigned lo, input int unsigned hi);
    int unsigned p;
    do p = $urandom_range(lo, hi); while (not_prime[p]);
    return p;
  endfunction

  // Mostly smooth products, which span the whole word yet keep the trial division short.
  function automatic logic [pf_pkg::IN_W-1:0] random_value();
    longint unsigned v;
    int unsigned     p;
    int unsigned     kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return $urandom_range(0, 15);
    if (kind <= 2) return $urandom_range(2, 65535);
    v = ($urandom_range(0, 3) == 0) ? random_prime(101, 2000) : 1;
    for (int k = 0; k < 40; k++) begin
      p = random_prime(2, ($urandom_range(0, 1) == 0) ? 7 : 97);
      if (v * p > 64'hFFFF_FFFF) break;
      v = v * p;
      if ($urandom_range(0, 15) == 0) break;
    end
    return v[pf_pkg::IN_W-1:0];
  endfunction

  task automatic send_value(input logic [pf_pkg::IN_W-1:0] value);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.value <= value;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    predict_factors(value);
    values_sent++;
  endtask

  task automatic wait_for_factors();
    din_if.valid <= 1'b0;
    while (pending_factors.size() != 0) @(posedge clk);
  endtask

  task automatic random_burst(input int unsigned n, input int unsigned src_pct,
                              input int unsigned snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < n; i++) send_value(random_value());
    wait_for_factors();
  endtask

  task automatic test_directed_values();
    logic [pf_pkg::IN_W-1:0] values [$] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd12, 32'd9409, 32'd65521, 32'd65536,
      32'd65537, 32'd999983, 32'd223092870, 32'h8000_0000, 32'd3486784401,
      32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'd1, 32'd0
    };
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    foreach (values[i]) send_value(values[i]);
    wait_for_factors();
  endtask

  task automatic test_largest_prime();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_value(32'd4294967291);
    wait_for_factors();
  endtask

  task automatic test_random_no_idling();
    random_burst(22, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    random_burst(11, 74, 0);
    random_burst(11, 74, 0);
  endtask

  task automatic test_random_receiver_stall();
    random_burst(22, 0, 74);
  endtask

  task automatic test_random_both_idle();
    random_burst(22, 12, 12);
  endtask

  always @(posedge clk) begin
    factor_word_t want;
    if (rst) begin
      dout_if.ready <= 1'b0;
    end else begin
      if (dout_if.valid && dout_if.ready) begin
        words_checked++;
        if (pending_factors.size() == 0) begin
          report_failure($sformatf("unexpected word: factor %0d exp %0d nf %0b last %0b",
                                   dout_if.prime_factor, dout_if.exponent,
                                   dout_if.no_factor, dout_if.last));
        end else begin
          want = pending_factors.pop_front();
          if (dout_if.prime_factor !== want.prime_factor || dout_if.exponent !== want.exponent
              || dout_if.no_factor !== want.no_factor || dout_if.last !== want.last) begin
            report_failure($sformatf(
              "mismatch: expected factor %0d exp %0d nf %0b last %0b, got %0d %0d %0b %0b",
              want.prime_factor, want.exponent, want.no_factor, want.last,
              dout_if.prime_factor, dout_if.exponent, dout_if.no_factor, dout_if.last));
          end
        end
      end
      dout_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  initial begin
    rst           <= 1'b1;
    din_if.valid  <= 1'b0;
    din_if.value  <= '0;
    build_prime_table();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_values();
    test_largest_prime();
    test_random_no_idling();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    repeat (100) @(posedge clk);
    if (pending_factors.size() != 0) begin
      report_failure($sformatf("%0d expected words never arrived", pending_factors.size()));
    end
    $display("Factorized %0d values, directed extremes and random smooth products,",
             values_sent);
    $display("with sender idling and receiver stalls; %0d words checked, %0d failures.",
             words_checked, failures);
    if (failures == 0) begin
      $display("prime_factorizer_tb OK");
    end else begin
      $display("prime_factorizer_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Timeout with %0d words outstanding.", pending_factors.size());
    $display("prime_factorizer_tb NOT OK");
    $finish;
  end

endmodule
